### rtl/ebp_pkg.sv
package ebp_pkg;

    localparam int GAIN_W = 16;
    localparam int FREQ_W = 17;
    localparam int MAG_W  = 17;
    localparam int Q_W    = 11;
    localparam int KIND_W = 2;
    localparam int THR_W  = 15;
    localparam int LIM_W  = 4;

    localparam logic [1:0] REG_PEAK_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_GAIN       = 2'd1;
    localparam logic [1:0] REG_MAX_BANDS      = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PEAK       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOW_SHELF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HIGH_SHELF = 2'd2;

    localparam logic [Q_W-1:0]    Q_SHELF       = 11'd179;
    localparam logic [Q_W-1:0]    Q_MIN         = 11'd128;
    localparam logic [Q_W-1:0]    Q_MAX         = 11'd1024;
    localparam logic [15:0]       Q_OFFSET      = 16'd1797;
    localparam logic [15:0]       RECIP_TEN     = 16'd52429;
    localparam int                RECIP_SHIFT   = 19;
    localparam logic [FREQ_W-1:0] LOW_SHELF_HZ  = 17'd200;
    localparam logic [FREQ_W-1:0] HIGH_SHELF_HZ = 17'd10000;

    localparam logic [THR_W-1:0] THR_RESET       = 15'd256;
    localparam logic [THR_W-1:0] MIN_GAIN_RESET  = 15'd256;
    localparam logic [LIM_W-1:0] MAX_BANDS_RESET = 4'd8;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain;
        logic [FREQ_W-1:0]        freq;
    } band_t;

    typedef struct packed {
        logic insert;
        logic emit_shift;
        logic occupied;
        logic in_range;
    } cell_ctl_t;

    function automatic logic [MAG_W-1:0] gain_mag(input logic signed [GAIN_W-1:0] g);
        logic signed [MAG_W-1:0] w;
        w = {g[GAIN_W-1], g};
        return w[MAG_W-1] ? MAG_W'(-w) : MAG_W'(w);
    endfunction

endpackage

### rtl/ebp_cell.sv
module ebp_cell (
    input  logic              clk,
    input  ebp_pkg::cell_ctl_t ctl,
    input  ebp_pkg::band_t     cand,
    input  ebp_pkg::band_t     prev_band,
    input  logic              prev_beat,
    input  ebp_pkg::band_t     next_band,
    output logic              beat,
    output ebp_pkg::band_t     band
);
    import ebp_pkg::*;

    band_t band_reg;
    band_t band_next;

    // an empty cell or a weaker entry loses to the candidate; ties keep the older one
    always_comb
    begin
        beat = !ctl.occupied || (gain_mag(band_reg.gain) < gain_mag(cand.gain));
        band_next = band_reg;
        if (ctl.emit_shift)
        begin
            band_next = next_band;
        end
        else if (ctl.insert && ctl.in_range && beat)
        begin
            band_next = prev_beat ? prev_band : cand;
        end
    end

    always_ff @(posedge clk)
    begin
        band_reg <= band_next;
    end

    assign band = band_reg;

endmodule

### rtl/ebp_band_fmt.sv
module ebp_band_fmt (
    input  ebp_pkg::band_t band,
    output logic [ebp_pkg::Q_W-1:0]    q,
    output logic [ebp_pkg::KIND_W-1:0] kind
);
    import ebp_pkg::*;

    logic [15:0] q_num;
    logic [31:0] q_prod;
    logic [12:0] q_raw;

    // divide by ten through the reciprocal, exact over this range
    assign q_num  = Q_OFFSET + 16'(gain_mag(band.gain));
    assign q_prod = 32'(q_num) * 32'(RECIP_TEN);
    assign q_raw  = q_prod[31:RECIP_SHIFT];

    always_comb
    begin
        if (band.freq < LOW_SHELF_HZ)
        begin
            kind = KIND_LOW_SHELF;
            q    = Q_SHELF;
        end
        else if (band.freq > HIGH_SHELF_HZ)
        begin
            kind = KIND_HIGH_SHELF;
            q    = Q_SHELF;
        end
        else
        begin
            kind = KIND_PEAK;
            if (q_raw < 13'(Q_MIN))
            begin
                q = Q_MIN;
            end
            else if (q_raw > 13'(Q_MAX))
            begin
                q = Q_MAX;
            end
            else
            begin
                q = q_raw[Q_W-1:0];
            end
        end
    end

endmodule

### rtl/eq_band_picker_top.sv
// eq_band_picker_top: picks parametric eq bands from a correction curve.
// s_axis: one curve point per item, tdata = point_gain, point_freq; tlast = last point.
// m_axis: one band per item, tdata = band_freq, band_gain, band_q;
//   tuser = band_kind, band_valid; tlast = final band of the curve.
// cfg: write channel, cfg_index 0 peak threshold, 1 minimum gain, 2 band limit;
//   cfg_ready is always high, writes take effect on the next item.
// while a curve streams in and no earlier result is still being emitted, one point is
// taken every cycle: the extremum test and the sorted insert into the row of MAX_BANDS
// cells both finish in the accept cycle. after the last point the bands load into the
// output register one per cycle while the receiver keeps up; the row of cells shifts one place
// towards the output for each band loaded, and the input is held until the final band is
// loaded (when no band was found a single empty result goes out).
// the input may take the next curve while the final band still waits in the output.
// when the receiver stalls the output register holds its item and the shift pauses.
// reset clears control state and restores the register defaults at once; the band
// cells need no clearing, so there is no sweep after reset.
module eq_band_picker_top #(
    parameter int MAX_BANDS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // point_gain[15:0], point_freq[32:16], zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // band_freq[16:0], band_gain[32:17], band_q[43:33], pad
    output logic [2:0]  m_tuser,   // band_kind[1:0], band_valid[2]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import ebp_pkg::*;

    localparam int CW = $clog2(MAX_BANDS + 1);

    logic [THR_W-1:0] peak_threshold_reg;
    logic [THR_W-1:0] min_gain_reg;
    logic [LIM_W-1:0] max_bands_reg;

    logic signed [GAIN_W-1:0] older_gain_reg;
    logic signed [GAIN_W-1:0] centre_gain_reg;
    logic [FREQ_W-1:0]        centre_freq_reg;
    logic [1:0]               points_seen_reg;
    logic [CW-1:0]            kept_count_reg, kept_count_next;

    logic          emit_reg;
    logic          none_reg;
    logic [CW-1:0] rem_reg;

    logic                 out_valid_reg;
    logic [FREQ_W-1:0]    out_freq_reg;
    logic [GAIN_W-1:0]    out_gain_reg;
    logic [Q_W-1:0]       out_q_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic                 out_band_valid_reg;
    logic                 out_last_reg;

    logic                     s_fire;
    logic signed [GAIN_W-1:0] in_gain;
    logic [FREQ_W-1:0]        in_freq;
    logic signed [MAG_W-1:0]  c_ext, o_ext, g_ext, thr_ext;
    logic                     is_peak, is_dip, is_cand;
    logic [CW-1:0]            lim, cnt, count_after;
    logic                     taken;
    logic                     ld;
    band_t                    cand;
    band_t                    bands [MAX_BANDS];
    logic                     beats [MAX_BANDS];
    cell_ctl_t                ctls  [MAX_BANDS];
    logic [Q_W-1:0]           fmt_q;
    logic [KIND_W-1:0]        fmt_kind;

    assign cfg_ready = 1'b1;
    assign s_tready  = !emit_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign in_gain   = s_tdata[15:0];
    assign in_freq   = s_tdata[32:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_threshold_reg <= THR_RESET;
            min_gain_reg       <= MIN_GAIN_RESET;
            max_bands_reg      <= MAX_BANDS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PEAK_THRESHOLD: peak_threshold_reg <= cfg_data;
                REG_MIN_GAIN:       min_gain_reg       <= cfg_data;
                REG_MAX_BANDS:      max_bands_reg      <= cfg_data[LIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // effective band limit and the visible part of the table
    always_comb
    begin
        if (max_bands_reg == '0)
        begin
            lim = CW'(1);
        end
        else if (32'(max_bands_reg) > MAX_BANDS)
        begin
            lim = CW'(MAX_BANDS);
        end
        else
        begin
            lim = CW'(max_bands_reg);
        end
        cnt = (kept_count_reg < lim) ? kept_count_reg : lim;
    end

    // strict extremum test on the centre point
    assign c_ext   = {centre_gain_reg[GAIN_W-1], centre_gain_reg};
    assign o_ext   = {older_gain_reg[GAIN_W-1], older_gain_reg};
    assign g_ext   = {in_gain[GAIN_W-1], in_gain};
    assign thr_ext = {2'b00, peak_threshold_reg};
    assign is_peak = (c_ext > o_ext) && (c_ext > g_ext) && (c_ext > thr_ext);
    assign is_dip  = (c_ext < o_ext) && (c_ext < g_ext) && (c_ext < -thr_ext);
    assign is_cand = (points_seen_reg == 2'd2) && (is_peak || is_dip)
                     && (gain_mag(centre_gain_reg) >= {2'b00, min_gain_reg});

    assign cand.gain = centre_gain_reg;
    assign cand.freq = centre_freq_reg;

    assign ld = emit_reg && (!out_valid_reg || m_tready);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BANDS; gi++)
        begin : g_cell
            assign ctls[gi].insert     = s_fire && is_cand;
            assign ctls[gi].emit_shift = ld && !none_reg;
            assign ctls[gi].occupied   = CW'(gi) < cnt;
            assign ctls[gi].in_range   = CW'(gi) < lim;

            if (gi == 0)
            begin : g_head
                if (MAX_BANDS > 1)
                begin : g_n
                    ebp_cell u_cell (
                        .clk       (clk),
                        .ctl       (ctls[gi]),
                        .cand      (cand),
                        .prev_band (cand),
                        .prev_beat (1'b0),
                        .next_band (bands[gi+1]),
                        .beat      (beats[gi]),
                        .band      (bands[gi])
                    );
                end
                else
                begin : g_one
                    ebp_cell u_cell (
                        .clk       (clk),
                        .ctl       (ctls[gi]),
                        .cand      (cand),
                        .prev_band (cand),
                        .prev_beat (1'b0),
                        .next_band (bands[gi]),
                        .beat      (beats[gi]),
                        .band      (bands[gi])
                    );
                end
            end
            else if (gi == MAX_BANDS - 1)
            begin : g_tail
                ebp_cell u_cell (
                    .clk       (clk),
                    .ctl       (ctls[gi]),
                    .cand      (cand),
                    .prev_band (bands[gi-1]),
                    .prev_beat (beats[gi-1]),
                    .next_band (bands[gi]),
                    .beat      (beats[gi]),
                    .band      (bands[gi])
                );
            end
            else
            begin : g_mid
                ebp_cell u_cell (
                    .clk       (clk),
                    .ctl       (ctls[gi]),
                    .cand      (cand),
                    .prev_band (bands[gi-1]),
                    .prev_beat (beats[gi-1]),
                    .next_band (bands[gi+1]),
                    .beat      (beats[gi]),
                    .band      (bands[gi])
                );
            end
        end
    endgenerate

    // the candidate lands somewhere iff some cell inside the limit loses to it
    always_comb
    begin
        taken = 1'b0;
        for (int i = 0; i < MAX_BANDS; i++)
        begin
            if (ctls[i].in_range && beats[i])
            begin
                taken = 1'b1;
            end
        end
        count_after = cnt;
        if (is_cand && taken)
        begin
            count_after = (cnt < lim) ? cnt + CW'(1) : lim;
        end
        // the count moves only on a candidate or a curve end; a raised limit sees old entries
        kept_count_next = kept_count_reg;
        if (s_fire)
        begin
            if (s_tlast)
            begin
                kept_count_next = '0;
            end
            else if (is_cand)
            begin
                kept_count_next = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_gain_reg  <= '0;
            centre_gain_reg <= '0;
            centre_freq_reg <= '0;
            points_seen_reg <= '0;
            kept_count_reg  <= '0;
        end
        else
        begin
            kept_count_reg <= kept_count_next;
            if (s_fire)
            begin
                older_gain_reg  <= centre_gain_reg;
                centre_gain_reg <= in_gain;
                centre_freq_reg <= in_freq;
                if (s_tlast)
                begin
                    points_seen_reg <= '0;
                end
                else if (points_seen_reg != 2'd2)
                begin
                    points_seen_reg <= points_seen_reg + 2'd1;
                end
            end
        end
    end

    ebp_band_fmt u_fmt (
        .band (bands[0]),
        .q    (fmt_q),
        .kind (fmt_kind)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg      <= 1'b0;
            none_reg      <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire && s_tlast)
            begin
                emit_reg <= 1'b1;
                none_reg <= (count_after == '0);
                rem_reg  <= count_after;
            end
            else if (ld)
            begin
                rem_reg <= rem_reg - CW'(1);
                if (none_reg || rem_reg == CW'(1))
                begin
                    emit_reg <= 1'b0;
                end
            end
            if (ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            if (none_reg)
            begin
                out_freq_reg       <= '0;
                out_gain_reg       <= '0;
                out_q_reg          <= '0;
                out_kind_reg       <= KIND_PEAK;
                out_band_valid_reg <= 1'b0;
                out_last_reg       <= 1'b1;
            end
            else
            begin
                out_freq_reg       <= bands[0].freq;
                out_gain_reg       <= bands[0].gain;
                out_q_reg          <= fmt_q;
                out_kind_reg       <= fmt_kind;
                out_band_valid_reg <= 1'b1;
                out_last_reg       <= (rem_reg == CW'(1));
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_q_reg, out_gain_reg, out_freq_reg};
    assign m_tuser  = {out_band_valid_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    // the visible table stays sorted strongest first
    generate
        for (gi = 1; gi < MAX_BANDS; gi++)
        begin : g_sorted
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (CW'(gi) < cnt) |-> (gain_mag(bands[gi-1].gain) >= gain_mag(bands[gi].gain)))
                else $error("band table out of order");
        end
    endgenerate

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(kept_count_reg) <= MAX_BANDS)
        else $error("kept count beyond table size");

    a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (emit_reg && !s_tready))
        else $error("last point did not start emission");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[2]) |-> m_tlast)
        else $error("empty result not marked last");

endmodule
